FILE: rtl/lhps_pkg.sv
// Package for the lamp and horn sequencer: types, codes and the horn segment ROM.
`timescale 1ns / 1ps
`default_nettype none
package lhps_pkg;

    // Field widths
    localparam int unsigned MS_W   = 12;
    localparam int unsigned HZ_W   = 12;
    localparam int unsigned CODE_W = 5;
    localparam int unsigned PAT_W  = 4;
    localparam int unsigned SEG_W  = 4;
    localparam int unsigned LEN_W  = SEG_W + 1;
    localparam int unsigned SUM_W  = MS_W + 1;

    // Longest pattern that is played; longer patterns end early
    localparam int unsigned MAX_SEGMENTS = 10;

    // Opcodes
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Command codes
    localparam logic [CODE_W-1:0] CMD_LAMP_LAST  = 5'd7;
    localparam logic [CODE_W-1:0] CMD_HORN_FIRST = 5'd8;
    localparam logic [CODE_W-1:0] CMD_HORN_LAST  = 5'd16;
    localparam logic [CODE_W-1:0] CMD_HORN_BASE  = 5'd7;

    // Lamp enable bits
    localparam int unsigned LAMP_LEFT   = 0;
    localparam int unsigned LAMP_RIGHT  = 1;
    localparam int unsigned LAMP_HIGH   = 2;
    localparam int unsigned LAMP_LOW    = 3;
    localparam int unsigned LAMP_FOG    = 4;
    localparam int unsigned LAMP_HAZARD = 5;
    localparam int unsigned LAMP_CABIN  = 6;
    localparam int unsigned LAMP_WIPER  = 7;

    // Register indexes
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_NORMAL_HZ   = 2'd1;
    localparam logic [1:0] REG_LOW_HZ      = 2'd2;

    // Register reset values
    localparam logic [MS_W-1:0] HALF_PERIOD_RST = 12'd500;
    localparam logic [HZ_W-1:0] NORMAL_HZ_RST   = 12'd1000;
    localparam logic [HZ_W-1:0] LOW_HZ_RST      = 12'd500;

    // Segment tones
    localparam logic [1:0] TONE_SILENT = 2'd0;
    localparam logic [1:0] TONE_NORMAL = 2'd1;
    localparam logic [1:0] TONE_LOW    = 2'd2;

    // Segment durations
    localparam logic [MS_W-1:0] DUR_HALF  = 12'd500;
    localparam logic [MS_W-1:0] DUR_ONE   = 12'd1000;
    localparam logic [MS_W-1:0] DUR_TWO   = 12'd2000;
    localparam logic [MS_W-1:0] DUR_THREE = 12'd3000;

    // Patterns
    localparam logic [PAT_W-1:0] PAT_NONE       = 4'd0;
    localparam logic [PAT_W-1:0] PAT_ONE_SEC    = 4'd1;
    localparam logic [PAT_W-1:0] PAT_TWO_SEC    = 4'd2;
    localparam logic [PAT_W-1:0] PAT_THREE_SEC  = 4'd3;
    localparam logic [PAT_W-1:0] PAT_TWO_BEEP   = 4'd4;
    localparam logic [PAT_W-1:0] PAT_THREE_BEEP = 4'd5;
    localparam logic [PAT_W-1:0] PAT_FOUR_BEEP  = 4'd6;
    localparam logic [PAT_W-1:0] PAT_LONG_SHORT = 4'd7;
    localparam logic [PAT_W-1:0] PAT_URGENT     = 4'd8;
    localparam logic [PAT_W-1:0] PAT_ALARM      = 4'd9;

    typedef struct packed {
        logic [MS_W-1:0] half_period_ms;
        logic [HZ_W-1:0] normal_hz;
        logic [HZ_W-1:0] low_hz;
    } lhps_cfg_t;

    // State handed from the sequencer to the output stage
    typedef struct packed {
        logic             accepted;
        logic [7:0]       lamps;
        logic             phase;
        logic [PAT_W-1:0] pattern;
        logic [SEG_W-1:0] segment;
    } lhps_status_t;

    // Result item, lowest field last
    typedef struct packed {
        logic [HZ_W-1:0] horn_tone_hz;
        logic            horn_on;
        logic            wiper_active;
        logic            cabin_lamp_on;
        logic            fog_lamp_on;
        logic            dipped_beam_lit;
        logic            main_beam_lit;
        logic            right_blinker_on;
        logic            left_blinker_on;
        logic            command_accepted;
    } lhps_result_t;

    // Number of segments played for a pattern
    function automatic logic [LEN_W-1:0] pattern_len(input logic [PAT_W-1:0] pat);
        logic [LEN_W-1:0] n;
        begin
            case (pat)
                PAT_ONE_SEC, PAT_TWO_SEC, PAT_THREE_SEC: n = 5'd1;
                PAT_TWO_BEEP, PAT_LONG_SHORT:            n = 5'd3;
                PAT_THREE_BEEP:                          n = 5'd5;
                PAT_FOUR_BEEP:                           n = 5'd7;
                PAT_URGENT:                              n = 5'd9;
                PAT_ALARM:                               n = 5'd10;
                default:                                 n = 5'd0;
            endcase
            if (n > LEN_W'(MAX_SEGMENTS))
            begin
                n = LEN_W'(MAX_SEGMENTS);
            end
            return n;
        end
    endfunction

    // Segment duration in milliseconds
    function automatic logic [MS_W-1:0] seg_dur(input logic [PAT_W-1:0] pat,
                                                input logic [SEG_W-1:0] idx);
        logic [MS_W-1:0] d;
        begin
            d = '0;
            case (pat)
                PAT_ONE_SEC:   d = (idx == 4'd0) ? DUR_ONE : '0;
                PAT_TWO_SEC:   d = (idx == 4'd0) ? DUR_TWO : '0;
                PAT_THREE_SEC: d = (idx == 4'd0) ? DUR_THREE : '0;
                PAT_TWO_BEEP:  d = (idx < 4'd3) ? DUR_ONE : '0;
                PAT_THREE_BEEP: d = (idx < 4'd5) ? DUR_ONE : '0;
                PAT_FOUR_BEEP: d = (idx < 4'd7) ? DUR_ONE : '0;
                PAT_LONG_SHORT:
                begin
                    if (idx == 4'd2)
                    begin
                        d = DUR_THREE;
                    end
                    else if (idx < 4'd2)
                    begin
                        d = DUR_ONE;
                    end
                end
                PAT_URGENT:    d = (idx < 4'd9) ? DUR_HALF : '0;
                PAT_ALARM:     d = (idx < 4'd10) ? DUR_ONE : '0;
                default:       d = '0;
            endcase
            return d;
        end
    endfunction

    // Segment tone
    function automatic logic [1:0] seg_tone(input logic [PAT_W-1:0] pat,
                                            input logic [SEG_W-1:0] idx);
        logic [1:0] t;
        begin
            t = TONE_SILENT;
            case (pat)
                PAT_ONE_SEC, PAT_TWO_SEC, PAT_THREE_SEC:
                    t = (idx == 4'd0) ? TONE_NORMAL : TONE_SILENT;
                PAT_TWO_BEEP, PAT_LONG_SHORT:
                    t = (idx < 4'd3 && !idx[0]) ? TONE_NORMAL : TONE_SILENT;
                PAT_THREE_BEEP:
                    t = (idx < 4'd5 && !idx[0]) ? TONE_NORMAL : TONE_SILENT;
                PAT_FOUR_BEEP:
                    t = (idx < 4'd7 && !idx[0]) ? TONE_NORMAL : TONE_SILENT;
                PAT_URGENT:
                    t = (idx < 4'd9 && !idx[0]) ? TONE_NORMAL : TONE_SILENT;
                PAT_ALARM:
                begin
                    if (idx < 4'd10)
                    begin
                        t = idx[0] ? TONE_NORMAL : TONE_LOW;
                    end
                end
                default: t = TONE_SILENT;
            endcase
            return t;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lhps_core.sv
// Sequencer with one shared subtractor: blink divider and horn segment walk.
`timescale 1ns / 1ps
`default_nettype none
module lhps_core
    import lhps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lhps_cfg_t         cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_opcode,
    input  wire logic [CODE_W-1:0] in_code,
    input  wire logic [MS_W-1:0]   in_ms,
    output logic                   done,
    input  wire logic              done_take,
    output lhps_status_t           status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_HCMP = 3'd2;
    localparam logic [2:0] ST_HSUB = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    logic [2:0]       state_reg, state_next;
    logic [7:0]       lamps_reg, lamps_next;
    logic             phase_reg, phase_next;
    logic [MS_W-1:0]  accum_reg, accum_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [MS_W-1:0]  left_reg, left_next;
    logic [MS_W-1:0]  ms_reg, ms_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             acc_reg, acc_next;

    logic [MS_W-1:0]  half_period;
    logic [SUM_W-1:0] shifted;
    logic [SUM_W-1:0] op_a, op_b;
    logic [SUM_W:0]   sub_full;
    logic [SUM_W-1:0] diff;
    logic             borrow;
    logic [LEN_W-1:0] seg_inc;
    logic [PAT_W-1:0] new_pat;
    logic [CODE_W-1:0] code_off;

    // Treat a zero half period as one millisecond
    assign half_period = (cfg.half_period_ms == '0) ? MS_W'(1) : cfg.half_period_ms;
    assign shifted     = {rem_reg[SUM_W-2:0], sum_reg[SUM_W-1]};
    assign seg_inc     = {1'b0, seg_reg} + LEN_W'(1);
    assign code_off    = in_code - CMD_HORN_BASE;
    assign new_pat     = code_off[PAT_W-1:0];

    // Pick operands for the shared subtractor
    always_comb
    begin
        case (state_reg)
            ST_DIV:
            begin
                op_a = shifted;
                op_b = {1'b0, half_period};
            end
            ST_HCMP:
            begin
                op_a = {1'b0, ms_reg};
                op_b = {1'b0, left_reg};
            end
            ST_HSUB:
            begin
                op_a = {1'b0, left_reg};
                op_b = {1'b0, ms_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign sub_full = {1'b0, op_a} - {1'b0, op_b};
    assign diff     = sub_full[SUM_W-1:0];
    assign borrow   = sub_full[SUM_W];

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        lamps_next = lamps_reg;
        phase_next = phase_reg;
        accum_next = accum_reg;
        pat_next   = pat_reg;
        seg_next   = seg_reg;
        left_next  = left_reg;
        ms_next    = ms_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next = 1'b0;
                    if (in_opcode == OP_COMMAND)
                    begin
                        state_next = ST_DONE;
                        if (in_code <= CMD_LAMP_LAST)
                        begin
                            lamps_next[in_code[2:0]] = 1'b1;
                            acc_next = 1'b1;
                        end
                        else if (in_code >= CMD_HORN_FIRST && in_code <= CMD_HORN_LAST)
                        begin
                            pat_next  = new_pat;
                            seg_next  = '0;
                            left_next = seg_dur(new_pat, '0);
                            acc_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_DIV;
                        sum_next   = {1'b0, accum_reg} + {1'b0, in_ms};
                        rem_next   = '0;
                        cnt_next   = CNT_W'(DIV_STEPS - 1);
                        ms_next    = in_ms;
                    end
                end
            end
            ST_DIV:
            begin
                // One restoring division step per cycle
                rem_next = borrow ? shifted : diff;
                sum_next = {sum_reg[SUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    accum_next = borrow ? shifted[MS_W-1:0] : diff[MS_W-1:0];
                    phase_next = phase_reg ^ !borrow;
                    if (pat_reg != PAT_NONE && ms_reg != '0)
                    begin
                        state_next = ST_HCMP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HCMP:
            begin
                if (borrow)
                begin
                    // Tick ends inside the current segment
                    state_next = ST_HSUB;
                end
                else
                begin
                    ms_next = diff[MS_W-1:0];
                    if (seg_inc >= pattern_len(pat_reg))
                    begin
                        pat_next   = PAT_NONE;
                        seg_next   = '0;
                        left_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        seg_next  = seg_inc[SEG_W-1:0];
                        left_next = seg_dur(pat_reg, seg_inc[SEG_W-1:0]);
                        if (diff[MS_W-1:0] == '0)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_HSUB:
            begin
                left_next  = diff[MS_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lamps_reg <= '0;
            phase_reg <= 1'b1;
            accum_reg <= '0;
            pat_reg   <= PAT_NONE;
            seg_reg   <= '0;
            left_reg  <= '0;
            ms_reg    <= '0;
            sum_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lamps_reg <= lamps_next;
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            pat_reg   <= pat_next;
            seg_reg   <= seg_next;
            left_reg  <= left_next;
            ms_reg    <= ms_next;
            sum_reg   <= sum_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign done            = (state_reg == ST_DONE);
    assign status.accepted = acc_reg;
    assign status.lamps    = lamps_reg;
    assign status.phase    = phase_reg;
    assign status.pattern  = pat_reg;
    assign status.segment  = seg_reg;

endmodule
`default_nettype wire

FILE: rtl/lhps_out_stage.sv
// Output stage: builds the result item from the state and holds it until taken.
`timescale 1ns / 1ps
`default_nettype none
module lhps_out_stage
    import lhps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire lhps_cfg_t    cfg,
    input  wire logic         done,
    input  wire lhps_status_t status,
    output logic              done_take,
    output logic              out_valid,
    input  wire logic         out_ready,
    output lhps_result_t      out_item
);

    logic         valid_reg, valid_next;
    lhps_result_t item_reg;
    lhps_result_t snap;
    logic         hazard;
    logic [1:0]   tone;
    logic [HZ_W-1:0] hz;

    // Look up the tone of the current segment
    always_comb
    begin
        tone = TONE_SILENT;
        if ({1'b0, status.segment} < pattern_len(status.pattern))
        begin
            tone = seg_tone(status.pattern, status.segment);
        end
        case (tone)
            TONE_NORMAL: hz = cfg.normal_hz;
            TONE_LOW:    hz = cfg.low_hz;
            default:     hz = '0;
        endcase
    end

    // Build the snapshot
    assign hazard                = status.lamps[LAMP_HAZARD];
    assign snap.command_accepted = status.accepted;
    assign snap.left_blinker_on  = status.phase & (status.lamps[LAMP_LEFT] | hazard);
    assign snap.right_blinker_on = status.phase & (status.lamps[LAMP_RIGHT] | hazard);
    assign snap.main_beam_lit    = status.lamps[LAMP_HIGH];
    assign snap.dipped_beam_lit  = status.lamps[LAMP_LOW];
    assign snap.fog_lamp_on      = status.lamps[LAMP_FOG];
    assign snap.cabin_lamp_on    = status.lamps[LAMP_CABIN];
    assign snap.wiper_active     = status.lamps[LAMP_WIPER];
    assign snap.horn_on          = (hz != '0);
    assign snap.horn_tone_hz     = hz;

    // Load when the register is empty or being drained
    assign done_take  = done && (!valid_reg || out_ready);
    assign valid_next = done_take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            item_reg <= snap;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

FILE: rtl/lamp_and_horn_pattern_sequencer_unit.sv
// Lamp and horn pattern sequencer: top level with configuration registers.
//
// Input channel s_axis: one item is a command (tuser 0) or a time tick (tuser 1).
//   A command latches a lamp enable or starts a horn pattern; a tick adds
//   elapsed milliseconds to the blink timer and walks the horn segments.
// Output channel m_axis: one result item per input item, a snapshot of the
//   lamp and horn outputs after the update, plus the command accepted flag.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 half period,
//   1 normal tone, 2 low tone); write only while the block is idle.
// Sequence: a command goes to the done state when it is taken, and its result is
//   loaded into the output register when the output stage takes it. A tick runs
//   13 divider steps on the shared subtractor, then compares the rest of the tick
//   against each horn segment in turn, finishing segments, and subtracts it from the
//   segment in which it ends; then the result is loaded. The next item is taken the
//   cycle after the result is loaded, so no item is taken before the last is finished.
// Reset: lamps off, blink phase on, horn idle, registers at 500, 1000, 500 Hz/ms.
// Stall: while m_axis_tready is low a finished result waits in the output register;
//   the sequencer can finish one more item, then holds it; s_axis_tready stays low.
`timescale 1ns / 1ps
`default_nettype none
module lamp_and_horn_pattern_sequencer_unit
    import lhps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [11:0] cfg_wdata,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [4:0] cmd_sel, [16:5] tick_ms
    input  wire logic [0:0]  s_axis_tuser,  // [0] opcode
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // [0] command_accepted, [1] left_blinker_on,
                                            // [2] right_blinker_on, [3] main_beam_lit,
                                            // [4] dipped_beam_lit, [5] fog_lamp_on,
                                            // [6] cabin_lamp_on, [7] wiper_active,
                                            // [8] horn_on, [20:9] horn_tone_hz
);

    lhps_cfg_t    cfg_reg;
    lhps_status_t status;
    lhps_result_t out_item;
    logic         done;
    logic         done_take;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ms <= HALF_PERIOD_RST;
            cfg_reg.normal_hz      <= NORMAL_HZ_RST;
            cfg_reg.low_hz         <= LOW_HZ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HALF_PERIOD: cfg_reg.half_period_ms <= cfg_wdata;
                REG_NORMAL_HZ:   cfg_reg.normal_hz      <= cfg_wdata;
                REG_LOW_HZ:      cfg_reg.low_hz         <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    lhps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser[0]),
        .in_code   (s_axis_tdata[4:0]),
        .in_ms     (s_axis_tdata[16:5]),
        .done      (done),
        .done_take (done_take),
        .status    (status)
    );

    lhps_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .done      (done),
        .status    (status),
        .done_take (done_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {3'b000, out_item};

endmodule
`default_nettype wire
